@@ rtl/core/eig_pkg.sv @@
// Package for the 2x2 symmetric eigenvalue pipeline.
// Holds the field widths and the square root stage payload type.
// No dependencies.
package eig_pkg;

  localparam int IN_W   = 24;  // e_term, f_term, g_term
  localparam int OUT_W  = 26;  // major_eigen, minor_eigen
  localparam int DIFF_W = 25;  // |e - g| and e + g
  localparam int AD2_W  = 49;  // (e - g)^2 is at most 2^48
  localparam int AF2_W  = 47;  // f^2 is at most 2^46
  localparam int RAD_W  = 50;  // (e - g)^2 + 4 f^2 is at most 2^49
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // Payload that walks down the square root pipeline.
  typedef struct packed {
    logic [RAD_W-1:0]         rad;   // radicand, consumed two bits per stage from the top
    logic signed [DIFF_W-1:0] sum;   // e + g
    logic [ROOT_W-1:0]        root;  // partial root
    logic [REM_W-1:0]         rem;   // partial remainder
  } eig_sq_t;

endpackage

@@ rtl/core/eig_if.sv @@
// Channel interfaces for the eigenvalue pipeline: tensor input and result output.
// Depends on eig_pkg.
interface eig_in_if;
  import eig_pkg::*;
  logic              valid;
  logic              ready;
  logic signed [IN_W-1:0] e_term;
  logic signed [IN_W-1:0] f_term;
  logic signed [IN_W-1:0] g_term;
  modport source (output valid, output e_term, output f_term, output g_term, input ready);
  modport sink   (input valid, input e_term, input f_term, input g_term, output ready);
endinterface

interface eig_out_if;
  import eig_pkg::*;
  logic              valid;
  logic              ready;
  logic signed [OUT_W-1:0] major_eigen;
  logic signed [OUT_W-1:0] minor_eigen;
  modport source (output valid, output major_eigen, output minor_eigen, input ready);
  modport sink   (input valid, input major_eigen, input minor_eigen, output ready);
endinterface

@@ rtl/core/eig_front.sv @@
// Front end of the eigenvalue pipeline: absolute values, squares and radicand.
// Three register stages. Depends on eig_pkg.
module eig_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [eig_pkg::IN_W-1:0]  e_term,
  input  logic signed [eig_pkg::IN_W-1:0]  f_term,
  input  logic signed [eig_pkg::IN_W-1:0]  g_term,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output eig_pkg::eig_sq_t                 dn_data
);
  import eig_pkg::*;

  logic                     a_v_r, b_v_r, c_v_r;
  logic                     rdy_a, rdy_b, rdy_c;
  logic [DIFF_W-1:0]        ad_r, ad_nxt;
  logic [IN_W-1:0]          af_r, af_nxt;
  logic signed [DIFF_W-1:0] sum_a_r, sum_b_r, sum_nxt;
  logic [AD2_W-1:0]         ad2_r;
  logic [AF2_W-1:0]         af2_r;
  logic [2*DIFF_W-1:0]      ad_sq;
  logic [2*IN_W-1:0]        af_sq;
  logic signed [DIFF_W-1:0] diff;
  eig_sq_t                  c_r, c_nxt;

  // A stage takes new data when it is empty or its content moves on.
  assign rdy_c    = !c_v_r || dn_ready;
  assign rdy_b    = !b_v_r || rdy_c;
  assign rdy_a    = !a_v_r || rdy_b;
  assign up_ready = rdy_a;

  always_comb begin
    diff    = DIFF_W'(e_term) - DIFF_W'(g_term);
    sum_nxt = DIFF_W'(e_term) + DIFF_W'(g_term);
    ad_nxt  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    af_nxt  = f_term[IN_W-1] ? IN_W'(-f_term) : IN_W'(f_term);
  end

  assign ad_sq = ad_r * ad_r;
  assign af_sq = af_r * af_r;

  always_comb begin
    c_nxt      = '0;
    c_nxt.rad  = RAD_W'({1'b0, ad2_r}) + RAD_W'({af2_r, 2'b00});
    c_nxt.sum  = sum_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= up_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy_a) begin
      ad_r    <= ad_nxt;
      af_r    <= af_nxt;
      sum_a_r <= sum_nxt;
    end
    if (a_v_r && rdy_b) begin
      ad2_r   <= ad_sq[AD2_W-1:0];
      af2_r   <= af_sq[AF2_W-1:0];
      sum_b_r <= sum_a_r;
    end
    if (b_v_r && rdy_c) begin
      c_r <= c_nxt;
    end
  end

  assign dn_valid = c_v_r;
  assign dn_data  = c_r;

endmodule

@@ rtl/core/eig_sqrt_stage.sv @@
// One stage of the pipelined integer square root: one root bit per stage.
// Depends on eig_pkg.
module eig_sqrt_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  eig_pkg::eig_sq_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output eig_pkg::eig_sq_t dn_data
);
  import eig_pkg::*;

  logic             v_r;
  eig_sq_t          d_r, d_nxt;
  logic [REM_W+1:0] rem_sh, trial;
  logic [REM_W+2:0] diff;

  assign up_ready = !v_r || dn_ready;

  // Bring down the next two radicand bits and try root*4 + 1.
  always_comb begin
    rem_sh    = {up_data.rem, up_data.rad[RAD_W-1 -: 2]};
    trial     = {2'b00, up_data.root, 2'b01};
    diff      = {1'b0, rem_sh} - {1'b0, trial};
    d_nxt     = up_data;
    d_nxt.rad = {up_data.rad[RAD_W-3:0], 2'b00};
    if (!diff[REM_W+2]) begin
      d_nxt.rem  = diff[REM_W-1:0];
      d_nxt.root = {up_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_sh[REM_W-1:0];
      d_nxt.root = {up_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // The remainder of a floor square root never exceeds twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid |-> ({1'b0, dn_data.rem} <= {2'b00, dn_data.root, 1'b0}))
    else $error("sqrt remainder exceeds twice the partial root");

  a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid && !dn_ready |=> dn_valid)
    else $error("stalled sqrt stage dropped its transaction");

  a_stall_data: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid && !dn_ready |=> $stable(dn_data))
    else $error("stalled sqrt stage changed its payload");

endmodule

@@ rtl/core/eig_back.sv @@
// Back end of the eigenvalue pipeline: forms (sum +/- root) >> 1 into the output register.
// Depends on eig_pkg.
module eig_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  eig_pkg::eig_sq_t                 up_data,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [eig_pkg::OUT_W-1:0] major_eigen,
  output logic signed [eig_pkg::OUT_W-1:0] minor_eigen
);
  import eig_pkg::*;

  logic                    v_r;
  logic signed [OUT_W:0]   hi_sum, lo_sum, sum_ext, root_ext;
  logic signed [OUT_W-1:0] major_r, minor_r;

  assign up_ready = !v_r || dn_ready;

  // Both sums fit OUT_W + 1 bits; dropping the low bit is the floor halving.
  always_comb begin
    sum_ext  = (OUT_W+1)'(up_data.sum);
    root_ext = signed'({2'b00, up_data.root});
    hi_sum   = sum_ext + root_ext;
    lo_sum   = sum_ext - root_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      major_r <= hi_sum[OUT_W:1];
      minor_r <= lo_sum[OUT_W:1];
    end
  end

  assign dn_valid    = v_r;
  assign major_eigen = major_r;
  assign minor_eigen = minor_r;

endmodule

@@ rtl/core/symmetric_2x2_eigenvalues.sv @@
// Eigenvalues of a symmetric 2x2 matrix [[E, F], [F, G]], fixed point, 12 fraction bits.
// The pipeline has 3 front stages (abs/sum, 25x25 and 24x24 squares, radicand add),
// 25 square root stages at one root bit each, and 1 output stage.
// Throughput is one transaction per clock; a stall backs up through per-stage ready.
// Synchronous active-low reset clears every valid bit; payload registers are not reset.
module symmetric_2x2_eigenvalues (
  input  logic      clk,
  input  logic      rst_n,
  eig_in_if.sink    in_chan,
  eig_out_if.source out_chan
);
  import eig_pkg::*;

  // Square root pipeline links: entry 0 is fed by the front end, entry ROOT_W
  // holds the finished root and feeds the output stage.
  logic    sq_valid [ROOT_W+1];
  logic    sq_ready [ROOT_W+1];
  eig_sq_t sq_data  [ROOT_W+1];

  // The front end computes |E - G|, |F|, E + G, then the squares, then the
  // radicand (E - G)^2 + 4 F^2, which stays below 2^50.
  eig_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .e_term   (in_chan.e_term),
    .f_term   (in_chan.f_term),
    .g_term   (in_chan.g_term),
    .dn_valid (sq_valid[0]),
    .dn_ready (sq_ready[0]),
    .dn_data  (sq_data[0])
  );

  // Digit-by-digit floor square root, most significant root bit first.
  // The radicand shifts left two bits in every stage so that each stage
  // looks at the same place and all stages are identical.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    eig_sqrt_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_valid[k]),
      .up_ready (sq_ready[k]),
      .up_data  (sq_data[k]),
      .dn_valid (sq_valid[k+1]),
      .dn_ready (sq_ready[k+1]),
      .dn_data  (sq_data[k+1])
    );
  end

  // The output register also acts as the last pipeline stage, so new
  // transactions keep flowing while a result waits as long as bubbles remain.
  eig_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (sq_valid[ROOT_W]),
    .up_ready    (sq_ready[ROOT_W]),
    .up_data     (sq_data[ROOT_W]),
    .dn_valid    (out_chan.valid),
    .dn_ready    (out_chan.ready),
    .major_eigen (out_chan.major_eigen),
    .minor_eigen (out_chan.minor_eigen)
  );

endmodule
